// ===== rtl/core/max_triangle_on_diameter_macros.svh =====
// Assertion macros for the max_triangle_on_diameter block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef MAX_TRIANGLE_ON_DIAMETER_MACROS_SVH
`define MAX_TRIANGLE_ON_DIAMETER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MTD_ASSERT_NOW(lbl, trig, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (expr)) \
      else $error("max_triangle_on_diameter: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define MTD_ASSERT_NEXT(lbl, trig, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("max_triangle_on_diameter: next-cycle check failed");

`endif

// ===== rtl/core/mtd_pkg.sv =====
// Shared types and constants of the max_triangle_on_diameter block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtd_pkg;

   // Width of the reported area word (17 fraction bits).
   localparam int AREA_WIDTH = 33;

   // Entries of the queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 4;

   // Queue fill state seen by both sides.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/mtd_front.sv =====
// Front end: takes point words from the command port and tags them.
// Depends on mtd_pkg for the queue status struct.
`default_nettype none

module mtd_front
   import mtd_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [COORD_WIDTH-1:0]     req_point_x,
   input  logic [COORD_WIDTH-1:0]     req_point_y,
   input  logic                       req_last_point,
   input  queue_status_type           q_status,
   output logic                       push,
   output logic [2*COORD_WIDTH:0]     push_item
);

   localparam int ITEM_W = 2 * COORD_WIDTH + 1;

   logic              stage_vld_ff;
   logic              stage_vld_in;
   logic [ITEM_W-1:0] stage_item_ff;
   logic [ITEM_W-1:0] stage_item_in;
   logic              take;

   // Hand the staged word on whenever the queue has room.
   assign push      = stage_vld_ff && !q_status.full;
   assign push_item = stage_item_ff;

   // Stall the port only when both the stage and the queue are occupied.
   assign busy = stage_vld_ff && q_status.full;
   assign take = start && !busy;

   // Load a new word, or drop the stage once its word has left.
   always_comb begin
      stage_vld_in  = stage_vld_ff;
      stage_item_in = stage_item_ff;
      if (take) begin
         stage_vld_in  = 1'b1;
         stage_item_in = {req_point_x, req_point_y, req_last_point};
      end else if (push) begin
         stage_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/mtd_queue.sv =====
// Small register queue between the front end and the compute engine.
// Depends on mtd_pkg for the depth and the status struct.
`default_nettype none

module mtd_queue
   import mtd_pkg::*;
#(
   parameter int ITEM_W = 33
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [ITEM_W-1:0] push_item,
   input  logic              pop,
   output logic [ITEM_W-1:0] pop_item,
   output queue_status_type  q_status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ITEM_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_item       = slot_ff[rd_ptr_ff];

   // Advance pointers; they wrap on their own since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mtd_back.sv =====
// Compute engine: point store, farthest-pair scan and triangle-area scan.
// Depends on mtd_pkg for the area width and the queue status struct.
`default_nettype none

module mtd_back
   import mtd_pkg::*;
#(
   parameter int MAX_POINTS  = 128,
   parameter int COORD_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  logic [2*COORD_WIDTH:0] pop_item,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [AREA_WIDTH-1:0] rsp_max_area,
   output logic                  rsp_overflow
);

   localparam int CW     = COORD_WIDTH;
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int WORD_W = 2 * CW;
   localparam int DIF_W  = CW + 1;
   localparam int SQ_W   = 2 * CW;
   localparam int DIST_W = 2 * CW + 1;
   localparam int PROD_W = 2 * DIF_W;
   localparam int CR_W   = PROD_W + 1;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_PAIR       = 3'd1;
   localparam logic [2:0] ST_PAIR_DRAIN = 3'd2;
   localparam logic [2:0] ST_AB_READ    = 3'd3;
   localparam logic [2:0] ST_AB_LOAD    = 3'd4;
   localparam logic [2:0] ST_AREA       = 3'd5;
   localparam logic [2:0] ST_AREA_DRAIN = 3'd6;
   localparam logic [2:0] ST_EMIT       = 3'd7;

   // Control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;

   // Point store
   logic [WORD_W-1:0] mem [MAX_POINTS];
   logic              mem_we;
   logic [IDX_W-1:0]  addr_a, addr_b;
   logic [WORD_W-1:0] rd_a_ff, rd_b_ff;

   // Incoming word fields
   logic [CW-1:0] in_x, in_y;
   logic          in_last;
   logic          room;

   // Pair scan pipeline
   logic             issue_pair;
   logic             p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic [IDX_W-1:0] p1_i_ff, p1_j_ff, p2_i_ff, p2_j_ff, p3_i_ff, p3_j_ff;
   logic [DIF_W-1:0] dif_x, dif_y;
   logic [CW-1:0]    mag_x, mag_y;
   logic [CW-1:0]    dx_ff, dy_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic [DIST_W-1:0] dist_sum;
   logic             pair_win;
   logic             have_best_ff, have_best_in;
   logic [DIST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0] end_a_ff, end_b_ff;

   // Area scan pipeline
   logic                     issue_area;
   logic                     q1_vld_ff, q2_vld_ff, q3_vld_ff, q4_vld_ff;
   logic [WORD_W-1:0]        a_word_ff, b_word_ff;
   logic [CW-1:0]            xa, ya, xb, yb, xp, yp;
   logic signed [DIF_W-1:0]  ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [PROD_W-1:0] m1_ff, m2_ff;
   logic signed [CR_W-1:0]   cross_ff;
   logic [CR_W-1:0]          cross_mag;
   logic [CR_W-1:0]          best_area_ff;
   logic                     area_clear;
   logic [CR_W+AREA_WIDTH-1:0] area_ext;

   assign in_x    = pop_item[2*CW:CW+1];
   assign in_y    = pop_item[CW:1];
   assign in_last = pop_item[0];
   assign room    = (count_ff < CNT_W'(MAX_POINTS));

   // Sequencer: load points, then pair scan, then area scan, then report.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      last_idx_in  = last_idx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      addr_a       = i_ff;
      addr_b       = j_ff;
      issue_pair   = 1'b0;
      issue_area   = 1'b0;
      area_clear   = 1'b0;
      rsp_valid    = 1'b0;
      have_best_in = have_best_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (room) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (in_last) begin
                  last_idx_in  = room ? count_ff[IDX_W-1:0] : IDX_W'(MAX_POINTS - 1);
                  i_in         = '0;
                  j_in         = '0;
                  have_best_in = 1'b0;
                  state_in     = ST_PAIR;
               end
            end
         end
         ST_PAIR: begin
            issue_pair = 1'b1;
            if (j_ff == last_idx_ff) begin
               j_in = '0;
               if (i_ff == last_idx_ff) begin
                  state_in = ST_PAIR_DRAIN;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_PAIR_DRAIN: begin
            if (!(p1_vld_ff || p2_vld_ff || p3_vld_ff)) begin
               state_in = ST_AB_READ;
            end
         end
         ST_AB_READ: begin
            addr_a   = end_a_ff;
            addr_b   = end_b_ff;
            state_in = ST_AB_LOAD;
         end
         ST_AB_LOAD: begin
            i_in       = '0;
            area_clear = 1'b1;
            state_in   = ST_AREA;
         end
         ST_AREA: begin
            issue_area = 1'b1;
            if (i_ff == last_idx_ff) begin
               state_in = ST_AREA_DRAIN;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         ST_AREA_DRAIN: begin
            if (!(q1_vld_ff || q2_vld_ff || q3_vld_ff || q4_vld_ff)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            count_in  = '0;
            drop_in   = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (pair_win) begin
         have_best_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         last_idx_ff  <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         have_best_ff <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         q1_vld_ff    <= 1'b0;
         q2_vld_ff    <= 1'b0;
         q3_vld_ff    <= 1'b0;
         q4_vld_ff    <= 1'b0;
         best_dist_ff <= '0;
         end_a_ff     <= '0;
         end_b_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         last_idx_ff  <= last_idx_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         have_best_ff <= have_best_in;
         p1_vld_ff    <= issue_pair;
         p2_vld_ff    <= p1_vld_ff;
         p3_vld_ff    <= p2_vld_ff;
         q1_vld_ff    <= issue_area;
         q2_vld_ff    <= q1_vld_ff;
         q3_vld_ff    <= q2_vld_ff;
         q4_vld_ff    <= q3_vld_ff;
         // Keep the first strictly farthest pair in scan order.
         if (pair_win) begin
            best_dist_ff <= dist_sum;
            end_a_ff     <= p3_i_ff;
            end_b_ff     <= p3_j_ff;
         end
      end
   end

   // Point memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= {in_x, in_y};
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // Pair scan: difference magnitudes, squares, then sum and compare.
   always_comb begin
      dif_x = {rd_a_ff[WORD_W-1], rd_a_ff[WORD_W-1:CW]}
            - {rd_b_ff[WORD_W-1], rd_b_ff[WORD_W-1:CW]};
      dif_y = {rd_a_ff[CW-1], rd_a_ff[CW-1:0]} - {rd_b_ff[CW-1], rd_b_ff[CW-1:0]};
      mag_x = dif_x[DIF_W-1] ? CW'(-dif_x) : dif_x[CW-1:0];
      mag_y = dif_y[DIF_W-1] ? CW'(-dif_y) : dif_y[CW-1:0];
      dist_sum = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
      pair_win = p3_vld_ff && (!have_best_ff || (dist_sum > best_dist_ff));
   end

   always_ff @(posedge clock) begin
      p1_i_ff <= i_ff;
      p1_j_ff <= j_ff;
      p2_i_ff <= p1_i_ff;
      p2_j_ff <= p1_j_ff;
      p3_i_ff <= p2_i_ff;
      p3_j_ff <= p2_j_ff;
      dx_ff   <= mag_x;
      dy_ff   <= mag_y;
      sqx_ff  <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff  <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
   end

   // Area scan: offsets from P, cross terms, their difference, then max.
   assign xa = a_word_ff[WORD_W-1:CW];
   assign ya = a_word_ff[CW-1:0];
   assign xb = b_word_ff[WORD_W-1:CW];
   assign yb = b_word_ff[CW-1:0];
   assign xp = rd_a_ff[WORD_W-1:CW];
   assign yp = rd_a_ff[CW-1:0];
   assign cross_mag = cross_ff[CR_W-1] ? $unsigned(-cross_ff) : $unsigned(cross_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_AB_LOAD) begin
         a_word_ff <= rd_a_ff;
         b_word_ff <= rd_b_ff;
      end
      ax_ff    <= $signed({xa[CW-1], xa}) - $signed({xp[CW-1], xp});
      ay_ff    <= $signed({ya[CW-1], ya}) - $signed({yp[CW-1], yp});
      bx_ff    <= $signed({xb[CW-1], xb}) - $signed({xp[CW-1], xp});
      by_ff    <= $signed({yb[CW-1], yb}) - $signed({yp[CW-1], yp});
      m1_ff    <= PROD_W'(ax_ff) * PROD_W'(by_ff);
      m2_ff    <= PROD_W'(ay_ff) * PROD_W'(bx_ff);
      cross_ff <= CR_W'(m1_ff) - CR_W'(m2_ff);
      if (area_clear) begin
         best_area_ff <= '0;
      end else if (q4_vld_ff && (cross_mag > best_area_ff)) begin
         best_area_ff <= cross_mag;
      end
   end

   // Report the low bits of the area and the drop flag of this set.
   assign area_ext     = {{AREA_WIDTH{1'b0}}, best_area_ff};
   assign rsp_max_area = area_ext[AREA_WIDTH-1:0];
   assign rsp_overflow = drop_ff;

endmodule

`default_nettype wire

// ===== rtl/core/max_triangle_on_diameter.sv =====
// Largest triangle on the farthest pair of a set of fixed-point points.
// Top level; instantiates mtd_front, mtd_queue and mtd_back, uses mtd_pkg.
//
// A point is taken on any cycle where start is high and busy is low; a
// front register and a four-entry queue take points while the engine works,
// so busy rises only once both are full; the engine pops only when idle.
// The point marked last launches the scan over the n stored points: n*n
// pairs, one pair per cycle through the two read ports of the point
// memory, then a drain of the pair pipeline, a read of the farthest pair,
// and an area scan over the n points that drains before the result goes out.
// The result shows on rsp_max_area and rsp_overflow for exactly one cycle
// with rsp_valid high; the receiver cannot stall it. Points past
// MAX_POINTS are dropped and flagged. The point memory needs no clearing.
`default_nettype none
`include "max_triangle_on_diameter_macros.svh"

module max_triangle_on_diameter
   import mtd_pkg::*;
#(
   parameter int MAX_POINTS  = 128,
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_point_x,
   input  logic [COORD_WIDTH-1:0] req_point_y,
   input  logic                   req_last_point,
   output logic                   rsp_valid,
   output logic [AREA_WIDTH-1:0]  rsp_max_area,
   output logic                   rsp_overflow
);

   localparam int ITEM_W = 2 * COORD_WIDTH + 1;

   queue_status_type  q_status;
   logic              push;
   logic              pop;
   logic [ITEM_W-1:0] push_item;
   logic [ITEM_W-1:0] pop_item;

   mtd_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   mtd_queue #(
      .ITEM_W (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   mtd_back #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .pop_item     (pop_item),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_max_area (rsp_max_area),
      .rsp_overflow (rsp_overflow)
   );

   // Result strobe lasts a single cycle.
   `MTD_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   // Front never writes a full queue.
   `MTD_ASSERT_NOW(a_no_push_full, push, !q_status.full)
   // Engine never reads an empty queue.
   `MTD_ASSERT_NOW(a_no_pop_empty, pop, !q_status.empty)

endmodule

`default_nettype wire
